@@ hw/rtl/lkc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared constants, codes and types of the keyed slot cache directory.
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int KEY_BITS   = 64;
    localparam int STAMP_BITS = 32;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int ACT_W = (CNT_W > 5) ? CNT_W : 5;

    localparam int REQ_TYPE_W = 2;
    localparam int KEY_W      = 64;
    localparam int SLOT_W     = 4;
    localparam int LEN_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 16;
    localparam int OFFSET_W   = 21;
    localparam int SLOTS_W    = 5;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_FIND    = 2'd0,
        REQ_RESERVE = 2'd1,
        REQ_COMMIT  = 2'd2
    } t_req_type;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic REG_SLOTS = 1'b0;
    localparam logic REG_CAP   = 1'b1;

    typedef struct packed {
        logic                  vld;
        logic                  match;
        logic [IDX_W-1:0]      match_idx;
        logic [LEN_W-1:0]      match_len;
        logic                  match_pres;
        logic                  free;
        logic [IDX_W-1:0]      free_idx;
        logic                  have_min;
        logic [IDX_W-1:0]      min_idx;
        logic [STAMP_BITS-1:0] min_stamp;
    } t_scan;

    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic                  set_key;
        logic [KEY_BITS-1:0]   key;
        logic                  stamp_en;
        logic [STAMP_BITS-1:0] stamp;
        logic                  len_en;
        logic [LEN_W-1:0]      len;
        logic                  pres;
    } t_wr;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [CAP_W-1:0]    capacity_out;
        logic [OFFSET_W-1:0] buffer_offset;
        logic [LEN_W-1:0]    stored_length;
        logic                stored_present;
    } t_res;

endpackage

@@ hw/rtl/lkc_if.sv @@
// ----------------------------------------------------------------------------
// lkc_req_if / lkc_res_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface lkc_req_if
    import lkc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [KEY_W-1:0]      lookup_key;
    logic [SLOT_W-1:0]     slot_index;
    logic [LEN_W-1:0]      entry_length;
    logic                  entry_valid;

    modport source (
        output valid, req_type, lookup_key, slot_index, entry_length, entry_valid,
        input  ready
    );
    modport sink (
        input  valid, req_type, lookup_key, slot_index, entry_length, entry_valid,
        output ready
    );
endinterface

interface lkc_res_if
    import lkc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [CAP_W-1:0]    capacity_out;
    logic [OFFSET_W-1:0] buffer_offset;
    logic [LEN_W-1:0]    stored_length;
    logic                stored_present;

    modport source (
        output valid, status, slot_out, capacity_out, buffer_offset,
               stored_length, stored_present,
        input  ready
    );
    modport sink (
        input  valid, status, slot_out, capacity_out, buffer_offset,
               stored_length, stored_present,
        output ready
    );
endinterface

@@ hw/rtl/lkc_cell.sv @@
// ----------------------------------------------------------------------------
// lkc_cell
// One directory slot: holds its key, used bit, stamp, length and present
// flag, folds itself into the scan record passing by, and applies writes.
// ----------------------------------------------------------------------------
module lkc_cell
    import lkc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [IDX_W-1:0]    i_index,
    input  logic [ACT_W-1:0]    i_active_n,
    input  logic [KEY_BITS-1:0] i_key,
    input  t_scan               i_scan,
    output t_scan               o_scan,
    input  t_wr                 i_wr
);

    logic [KEY_BITS-1:0]   r_key;
    logic                  r_used;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [LEN_W-1:0]      r_len;
    logic                  r_pres;
    t_scan                 r_scan;
    t_scan                 n_scan;
    logic                  w_active;

    assign w_active = ACT_W'(i_index) < i_active_n;

    always_comb begin
        n_scan = i_scan;
        if (i_scan.vld && w_active) begin
            if (r_used && (r_key == i_key) && !i_scan.match) begin
                n_scan.match      = 1'b1;
                n_scan.match_idx  = i_index;
                n_scan.match_len  = r_len;
                n_scan.match_pres = r_pres;
            end
            if (!r_used && !i_scan.free) begin
                n_scan.free     = 1'b1;
                n_scan.free_idx = i_index;
            end
            if (r_used && (!i_scan.have_min || (r_stamp < i_scan.min_stamp))) begin
                n_scan.have_min  = 1'b1;
                n_scan.min_idx   = i_index;
                n_scan.min_stamp = r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_pres <= 1'b0;
        end else if (i_wr.en && (i_wr.idx == i_index)) begin
            if (i_wr.set_key) begin
                r_key  <= i_wr.key;
                r_used <= 1'b1;
            end
            if (i_wr.stamp_en) begin
                r_stamp <= i_wr.stamp;
            end
            if (i_wr.len_en) begin
                r_len  <= i_wr.len;
                r_pres <= i_wr.pres;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

@@ hw/rtl/lru_keyed_slot_cache.sv @@
// ----------------------------------------------------------------------------
// lru_keyed_slot_cache
// Directory of a fully associative slot cache with timestamp LRU replacement.
// ----------------------------------------------------------------------------
// Each request item walks a row of NUM_SLOTS slot cells, one cell per cycle,
// collecting the first key match, the first unused slot and the oldest stamp;
// the slot update is applied when the walk leaves the last cell. One item is
// in flight at a time: the next item is accepted only after the finished
// result has moved from the pending register into the output register, a move
// that stalls while the output register is full and not taken. A finished
// result waits in the output register while the next item is already being
// accepted. Registers: slots_in_use at byte address 0 and entry_capacity at byte address 4.
// ----------------------------------------------------------------------------
module lru_keyed_slot_cache
    import lkc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkc_req_if.sink     i_req,
    lkc_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SLOTS_W-1:0]    r_slots;
    logic [CAP_W-1:0]      r_cap;
    logic [STAMP_BITS-1:0] r_clock;
    logic                  r_busy;
    logic                  r_start;
    t_req_type             r_type;
    logic [KEY_BITS-1:0]   r_key;
    logic [SLOT_W-1:0]     r_idx;
    logic [LEN_W-1:0]      r_len;
    logic                  r_valid;
    t_res                  r_pend;
    logic                  r_pend_vld;
    t_res                  r_out;
    logic                  r_out_vld;

    t_scan                 w_head;
    t_scan                 w_scan [NUM_SLOTS+1];
    t_scan                 w_end;
    t_wr                   w_wr;
    t_res                  w_res;
    logic [ACT_W-1:0]      w_n;
    logic [IDX_W-1:0]      w_victim;
    logic [STAMP_BITS-1:0] w_tick;
    logic [IDX_W+16:0]     w_prod;
    logic                  w_accept;
    logic                  w_pend_move;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAP) ? {16'd0, r_cap} : {27'd0, r_slots};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SLOTS_W'(16);
            r_cap   <= CAP_W'(255);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_CAP) begin
                r_cap <= pwdata[CAP_W-1:0];
            end else begin
                r_slots <= pwdata[SLOTS_W-1:0];
            end
        end
    end

    assign w_n = (ACT_W'(r_slots) > ACT_W'(NUM_SLOTS)) ? ACT_W'(NUM_SLOTS) : ACT_W'(r_slots);

    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type  <= t_req_type'(i_req.req_type);
            r_key   <= i_req.lookup_key[KEY_BITS-1:0];
            r_idx   <= i_req.slot_index;
            r_len   <= i_req.entry_length;
            r_valid <= i_req.entry_valid;
        end
    end

    always_comb begin
        w_head     = '0;
        w_head.vld = r_start;
    end

    assign w_scan[0] = w_head;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        lkc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (IDX_W'(g)),
            .i_active_n (w_n),
            .i_key      (r_key),
            .i_scan     (w_scan[g]),
            .o_scan     (w_scan[g+1]),
            .i_wr       (w_wr)
        );
    end

    assign w_end    = w_scan[NUM_SLOTS];
    assign w_tick   = r_clock + STAMP_BITS'(1);
    assign w_victim = w_end.match ? w_end.match_idx :
                      (w_end.free ? w_end.free_idx : w_end.min_idx);
    assign w_prod   = (IDX_W+17)'(w_victim) * (IDX_W+17)'(17'(r_cap) + 17'd1);

    always_comb begin
        w_res        = '0;
        w_wr         = '0;
        w_wr.key     = r_key;
        w_wr.stamp   = w_tick;
        case (r_type)
            REQ_FIND: begin
                if (w_end.match) begin
                    w_res.status         = ST_OK;
                    w_res.slot_out       = SLOT_W'(w_end.match_idx);
                    w_res.stored_length  = w_end.match_len;
                    w_res.stored_present = w_end.match_pres;
                    w_wr.en              = w_end.vld;
                    w_wr.idx             = w_end.match_idx;
                    w_wr.stamp_en        = 1'b1;
                end else begin
                    w_res.status = ST_MISS;
                end
            end
            REQ_RESERVE: begin
                if (w_n == '0) begin
                    w_res.status = ST_INVALID;
                end else begin
                    w_res.status        = ST_OK;
                    w_res.slot_out      = SLOT_W'(w_victim);
                    w_res.capacity_out  = r_cap;
                    w_res.buffer_offset = OFFSET_W'(w_prod);
                    w_wr.en             = w_end.vld;
                    w_wr.idx            = w_victim;
                    w_wr.set_key        = 1'b1;
                    w_wr.stamp_en       = 1'b1;
                    w_wr.len_en         = 1'b1;
                    w_wr.len            = '0;
                    w_wr.pres           = 1'b0;
                end
            end
            REQ_COMMIT: begin
                if (ACT_W'(r_idx) < w_n) begin
                    w_res.status   = ST_OK;
                    w_res.slot_out = r_idx;
                    w_wr.en        = w_end.vld;
                    w_wr.idx       = IDX_W'(r_idx);
                    w_wr.len_en    = 1'b1;
                    w_wr.len       = (r_len > r_cap) ? r_cap : r_len;
                    w_wr.pres      = r_valid;
                end else begin
                    w_res.status = ST_INVALID;
                end
            end
            default: begin
                w_res.status = ST_INVALID;
            end
        endcase
    end

    assign w_pend_move = r_pend_vld && (!r_out_vld || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (w_end.vld) begin
            r_pend <= w_res;
        end
        if (w_pend_move) begin
            r_out <= r_pend;
        end
        if (!i_rst_n) begin
            r_clock    <= '0;
            r_busy     <= 1'b0;
            r_start    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_start <= w_accept;
            if (w_wr.en && w_wr.stamp_en) begin
                r_clock <= w_tick;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_pend_move) begin
                r_busy <= 1'b0;
            end
            if (w_end.vld) begin
                r_pend_vld <= 1'b1;
            end else if (w_pend_move) begin
                r_pend_vld <= 1'b0;
            end
            if (w_pend_move) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.status         = r_out.status;
    assign o_res.slot_out       = r_out.slot_out;
    assign o_res.capacity_out   = r_out.capacity_out;
    assign o_res.buffer_offset  = r_out.buffer_offset;
    assign o_res.stored_length  = r_out.stored_length;
    assign o_res.stored_present = r_out.stored_present;

endmodule

@@ bench/lru_keyed_slot_cache_tb.sv @@
// ----------------------------------------------------------------------------
// lru_keyed_slot_cache_tb
// Self-checking bench for the keyed slot cache directory. A shadow copy of the
// slot table predicts every reply item when its request is accepted, and the
// replies are compared in order. Directed requests cover the corner cases,
// then phases of random requests run under different register settings, most
// of them with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module lru_keyed_slot_cache_tb;
    import lkc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int POOL_MAX = 24;
    localparam int NUM_PHASES = 7;

    typedef struct {
        logic [REQ_TYPE_W-1:0] kind;
        logic [KEY_W-1:0]      key;
        logic [SLOT_W-1:0]     slot;
        logic [LEN_W-1:0]      len;
        logic                  pres;
    } t_dir_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lkc_req_if req_if ();
    lkc_res_if res_if ();

    lru_keyed_slot_cache i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the slot table and registers.
    logic [KEY_BITS-1:0]   shadow_key [NUM_SLOTS];
    logic                  shadow_used [NUM_SLOTS];
    logic [STAMP_BITS-1:0] shadow_stamp [NUM_SLOTS];
    logic [LEN_W-1:0]      shadow_len [NUM_SLOTS];
    logic                  shadow_pres [NUM_SLOTS];
    logic [STAMP_BITS-1:0] shadow_clock = '0;
    logic [SLOTS_W-1:0]    active_cfg = 5'd16;
    logic [CAP_W-1:0]      capacity_cfg = 16'd255;

    t_dir_req outgoing_requests[$];
    t_res     pending_replies[$];
    logic [KEY_W-1:0] key_pool [POOL_MAX];
    int  pool_size = 1;
    int  queued_cnt = 0;
    int  accepted_cnt = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  calm = 1'b1;
    bit  req_fired = 1'b0;
    logic [31:0] stall_pat = 32'hFFFF_FFFF;
    logic [4:0]  stall_pos = '0;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_key[i] = '0;
            shadow_used[i] = 1'b0;
            shadow_stamp[i] = '0;
            shadow_len[i] = '0;
            shadow_pres[i] = 1'b0;
        end
    end

    function automatic t_res lookup_outcome(t_dir_req r);
        t_res res;
        int n;
        int hit;
        int victim;
        logic [31:0] offset;
        logic [LEN_W-1:0] clamped;
        res = '0;
        n = (active_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(active_cfg);
        hit = -1;
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && shadow_used[i] && shadow_key[i] == r.key) hit = i;
        end
        case (r.kind)
            REQ_FIND: begin
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    shadow_clock = shadow_clock + 1'b1;
                    shadow_stamp[hit] = shadow_clock;
                    res.status = ST_OK;
                    res.slot_out = hit[SLOT_W-1:0];
                    res.stored_length = shadow_len[hit];
                    res.stored_present = shadow_pres[hit];
                end
            end
            REQ_RESERVE: begin
                if (n == 0) begin
                    res.status = ST_INVALID;
                end else begin
                    if (hit >= 0) begin
                        victim = hit;
                    end else begin
                        victim = 0;
                        for (int i = 0; i < n; i++) begin
                            if (!shadow_used[i]) begin
                                victim = i;
                                break;
                            end
                            if (shadow_stamp[i] < shadow_stamp[victim]) victim = i;
                        end
                    end
                    shadow_key[victim] = r.key;
                    shadow_len[victim] = '0;
                    shadow_pres[victim] = 1'b0;
                    shadow_used[victim] = 1'b1;
                    shadow_clock = shadow_clock + 1'b1;
                    shadow_stamp[victim] = shadow_clock;
                    offset = victim * (32'(capacity_cfg) + 32'd1);
                    res.status = ST_OK;
                    res.slot_out = victim[SLOT_W-1:0];
                    res.capacity_out = capacity_cfg;
                    res.buffer_offset = offset[OFFSET_W-1:0];
                end
            end
            REQ_COMMIT: begin
                if (int'(r.slot) >= n) begin
                    res.status = ST_INVALID;
                end else begin
                    clamped = (r.len > capacity_cfg) ? capacity_cfg : r.len;
                    shadow_len[r.slot] = clamped;
                    shadow_pres[r.slot] = r.pres;
                    res.status = ST_OK;
                    res.slot_out = r.slot;
                end
            end
            default: res.status = ST_INVALID;
        endcase
        return res;
    endfunction

    function automatic void check_reply(t_res got);
        t_res want;
        bit bad;
        if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reply with nothing expected: status %0d slot %0d",
                         got.status, got.slot_out);
            return;
        end
        want = pending_replies.pop_front();
        bad = (got.status !== want.status) || (got.slot_out !== want.slot_out) ||
              (got.capacity_out !== want.capacity_out) ||
              (got.buffer_offset !== want.buffer_offset) ||
              (got.stored_length !== want.stored_length) ||
              (got.stored_present !== want.stored_present);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"reply mismatch (exp/got): status %0d/%0d slot %0d/%0d ",
                          "cap %0d/%0d off %0d/%0d len %0d/%0d pres %0d/%0d"},
                         want.status, got.status, want.slot_out, got.slot_out,
                         want.capacity_out, got.capacity_out,
                         want.buffer_offset, got.buffer_offset,
                         want.stored_length, got.stored_length,
                         want.stored_present, got.stored_present);
        end
    endfunction

    function automatic void queue_request(logic [REQ_TYPE_W-1:0] kind, logic [KEY_W-1:0] key,
                                          logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] len,
                                          logic pres);
        t_dir_req r;
        r.kind = kind;
        r.key = key;
        r.slot = slot;
        r.len = len;
        r.pres = pres;
        outgoing_requests.push_back(r);
        queued_cnt++;
    endfunction

    function automatic void refill_key_pool(int n);
        pool_size = (n + 4 > POOL_MAX) ? POOL_MAX : n + 4;
        for (int i = 0; i < POOL_MAX; i++) key_pool[i] = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) key_pool[0] = '0;
        if ($urandom_range(0, 1) == 0) key_pool[1] = '1;
    endfunction

    function automatic void queue_random_request(int n);
        int sel;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0] len;
        sel = $urandom_range(0, 99);
        key = key_pool[$urandom_range(0, pool_size - 1)];
        slot = SLOT_W'($urandom_range(0, 15));
        len = LEN_W'($urandom_range(0, 65535));
        if (sel < 5) begin
            queue_request(REQ_UNKNOWN, {$urandom, $urandom}, slot, len,
                          1'($urandom_range(0, 1)));
        end else if (sel < 40) begin
            queue_request(REQ_RESERVE, key, slot, len, 1'($urandom_range(0, 1)));
        end else if (sel < 70) begin
            queue_request(REQ_FIND, key, slot, len, 1'($urandom_range(0, 1)));
        end else if (sel < 76) begin
            queue_request(sel[0] ? REQ_FIND : REQ_RESERVE, {$urandom, $urandom}, slot, len,
                          1'($urandom_range(0, 1)));
        end else begin
            if (n > 0 && $urandom_range(0, 4) != 0) slot = SLOT_W'($urandom_range(0, n - 1));
            case ($urandom_range(0, 3))
                0: len = capacity_cfg;
                1: len = capacity_cfg + 1'b1;
                2: len = LEN_W'($urandom_range(0, 15));
                default: ;
            endcase
            queue_request(REQ_COMMIT, {$urandom, $urandom}, slot, len,
                          1'($urandom_range(0, 1)));
        end
    endfunction

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_directory(input int slots, input int cap);
        write_reg({REG_SLOTS, 2'b00}, 32'(slots));
        active_cfg = slots[SLOTS_W-1:0];
        write_reg({REG_CAP, 2'b00}, 32'(cap));
        capacity_cfg = cap[CAP_W-1:0];
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_cnt != queued_cnt || pending_replies.size() != 0);
    endtask

    // Request driver: bursts of items separated by random gaps.
    always @(negedge i_clk) begin
        t_dir_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fired) begin
            if (gap_left > 0 && !calm) begin
                gap_left <= gap_left - 1;
                req_if.valid <= 1'b0;
            end else if (outgoing_requests.size() > 0) begin
                nxt = outgoing_requests.pop_front();
                req_if.valid <= 1'b1;
                req_if.req_type <= nxt.kind;
                req_if.lookup_key <= nxt.key;
                req_if.slot_index <= nxt.slot;
                req_if.entry_length <= nxt.len;
                req_if.entry_valid <= nxt.pres;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Reply receiver: ready follows a rotating stall pattern, or stays high in a calm phase.
    always @(negedge i_clk) begin
        res_if.ready <= calm ? 1'b1 : stall_pat[stall_pos];
        stall_pos <= stall_pos + 1'b1;
        if (stall_pos == 5'd31) begin
            case ($urandom_range(0, 3))
                0: stall_pat <= $urandom & $urandom;
                1: stall_pat <= 32'hFFFF_FFFF;
                default: stall_pat <= $urandom | $urandom;
            endcase
        end
    end

    // Monitor: predicts on request acceptance, checks on reply acceptance.
    always @(posedge i_clk) begin
        t_dir_req acc;
        t_res got;
        if (!i_rst_n) begin
            req_fired <= 1'b0;
            idle_cycles <= 0;
        end else begin
            req_fired <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                acc.kind = req_if.req_type;
                acc.key = req_if.lookup_key;
                acc.slot = req_if.slot_index;
                acc.len = req_if.entry_length;
                acc.pres = req_if.entry_valid;
                pending_replies.push_back(lookup_outcome(acc));
                accepted_cnt++;
            end
            if (res_if.valid && res_if.ready) begin
                got.status = res_if.status;
                got.slot_out = res_if.slot_out;
                got.capacity_out = res_if.capacity_out;
                got.buffer_offset = res_if.buffer_offset;
                got.stored_length = res_if.stored_length;
                got.stored_present = res_if.stored_present;
                check_reply(got);
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("lru_keyed_slot_cache_tb NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int phase_slots [NUM_PHASES] = '{0, 1, 31, 5, 16, -1, 8};
        int phase_cap [NUM_PHASES] = '{0, 0, 65535, -1, 1, -1, 255};
        int phase_items [NUM_PHASES] = '{30, 150, 170, 170, 170, 170, 190};
        bit phase_calm [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0};
        int slots;
        int cap;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_FIND;
        req_if.lookup_key = '0;
        req_if.slot_index = '0;
        req_if.entry_length = '0;
        req_if.entry_valid = 1'b0;
        res_if.ready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_request(REQ_FIND, '0, 4'd0, 16'd0, 1'b0);
        queue_request(REQ_RESERVE, '0, 4'd15, 16'hFFFF, 1'b1);
        queue_request(REQ_FIND, '0, 4'd0, 16'd0, 1'b0);
        queue_request(REQ_RESERVE, '1, 4'd0, 16'd0, 1'b0);
        queue_request(REQ_COMMIT, '0, 4'd1, 16'hFFFF, 1'b1);
        queue_request(REQ_FIND, '1, 4'd0, 16'd0, 1'b0);
        queue_request(REQ_COMMIT, '1, 4'd15, 16'd0, 1'b0);
        queue_request(REQ_UNKNOWN, {$urandom, $urandom}, 4'hF, 16'hFFFF, 1'b1);
        queue_request(REQ_RESERVE, '0, 4'd0, 16'd0, 1'b0);
        for (int k = 2; k < NUM_SLOTS; k++)
            queue_request(REQ_RESERVE, 64'(k) << (4 * k), 4'(k), 16'(k), 1'b0);
        queue_request(REQ_RESERVE, 64'hA5A5_5A5A_0F0F_F0F0, 4'd0, 16'd0, 1'b0);
        queue_request(REQ_FIND, '1, 4'd0, 16'd0, 1'b0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            slots = (phase_slots[p] < 0) ? $urandom_range(0, 31) : phase_slots[p];
            cap = (phase_cap[p] < 0) ? $urandom_range(0, 65535) : phase_cap[p];
            program_directory(slots, cap);
            calm = phase_calm[p];
            refill_key_pool((slots > NUM_SLOTS) ? NUM_SLOTS : slots);
            for (int k = 0; k < phase_items[p]; k++)
                queue_random_request((slots > NUM_SLOTS) ? NUM_SLOTS : slots);
            wait_drained();
        end

        repeat (4 * NUM_SLOTS) @(posedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("lru_keyed_slot_cache_tb OK");
        end else begin
            $display("lru_keyed_slot_cache_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/lkc_pkg.sv
hw/rtl/lkc_if.sv
hw/rtl/lkc_cell.sv
hw/rtl/lru_keyed_slot_cache.sv
bench/lru_keyed_slot_cache_tb.sv
